>>> src/sorted_reference_set_intersection_top_assert.svh
// assertion macros used by the top-level rtl
`ifndef SORTED_REFERENCE_SET_INTERSECTION_TOP_ASSERT_SVH
`define SORTED_REFERENCE_SET_INTERSECTION_TOP_ASSERT_SVH

// a true at a clock edge requires b at the same edge
`define SRSI_ASSERT_SAME(name, clk, rstn, a, b) \
  name: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("same-cycle check failed");

// a true at a clock edge requires b at the next edge
`define SRSI_ASSERT_NEXT(name, clk, rstn, a, b) \
  name: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

>>> src/srsi_pkg.sv
`timescale 1ns / 1ps

package srsi_pkg;

  // fixed field widths of the stream words
  localparam int unsigned ModeW       = 2;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned RefInW      = 32;
  localparam int unsigned IndexInW    = 10;
  localparam int unsigned CountOutW   = 11;
  localparam int unsigned InTdataW    = 48;
  localparam int unsigned OutTdataW   = 48;
  localparam int unsigned OutPadW     = OutTdataW - CountOutW - RefInW;

  typedef enum logic [ModeW-1:0] {
    MODE_NEW   = 2'd0,
    MODE_PUSH  = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_ORDER = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY_RD,
    S_COPY_WR,
    S_SET_RD,
    S_PROBE,
    S_CMP,
    S_CLOSE_END,
    S_DONE
  } state_e;

  // controller to datapath, at most one bit set per cycle
  typedef struct packed {
    logic accept;
    logic copy_rd;
    logic copy_wr;
    logic set_rd;
    logic probe;
    logic cmp;
    logic close_end;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic first;
    logic set_empty;
    logic list_empty;
    logic lo_lt_hi;
    logic match;
    logic walk_last;
    logic copy_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/srsi_ctrl.sv
`timescale 1ns / 1ps

module srsi_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srsi_pkg::mode_e      mode_i,
  input  srsi_pkg::dp_status_t status_i,
  output srsi_pkg::dp_cmd_t    cmd_o
);

  srsi_pkg::state_e state_q, state_d;

  assign in_ready_o = (state_q == srsi_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      srsi_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == srsi_pkg::MODE_CLOSE) begin
            if (status_i.first) begin
              state_d = status_i.list_empty ? srsi_pkg::S_CLOSE_END : srsi_pkg::S_COPY_RD;
            end else begin
              state_d = status_i.set_empty ? srsi_pkg::S_CLOSE_END : srsi_pkg::S_SET_RD;
            end
          end else begin
            state_d = srsi_pkg::S_DONE;
          end
        end
      end
      srsi_pkg::S_COPY_RD: state_d = srsi_pkg::S_COPY_WR;
      srsi_pkg::S_COPY_WR: begin
        state_d = status_i.copy_last ? srsi_pkg::S_CLOSE_END : srsi_pkg::S_COPY_RD;
      end
      srsi_pkg::S_SET_RD: state_d = srsi_pkg::S_PROBE;
      srsi_pkg::S_PROBE: begin
        if (status_i.lo_lt_hi) begin
          state_d = srsi_pkg::S_CMP;
        end else begin
          state_d = status_i.walk_last ? srsi_pkg::S_CLOSE_END : srsi_pkg::S_SET_RD;
        end
      end
      srsi_pkg::S_CMP: begin
        if (status_i.match) begin
          state_d = status_i.walk_last ? srsi_pkg::S_CLOSE_END : srsi_pkg::S_SET_RD;
        end else begin
          state_d = srsi_pkg::S_PROBE;
        end
      end
      srsi_pkg::S_CLOSE_END: state_d = srsi_pkg::S_DONE;
      srsi_pkg::S_DONE: begin
        if (status_i.out_free) begin
          state_d = srsi_pkg::S_IDLE;
        end
      end
      default: state_d = srsi_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      srsi_pkg::S_IDLE:      cmd_o.accept    = in_valid_i;
      srsi_pkg::S_COPY_RD:   cmd_o.copy_rd   = 1'b1;
      srsi_pkg::S_COPY_WR:   cmd_o.copy_wr   = 1'b1;
      srsi_pkg::S_SET_RD:    cmd_o.set_rd    = 1'b1;
      srsi_pkg::S_PROBE:     cmd_o.probe     = 1'b1;
      srsi_pkg::S_CMP:       cmd_o.cmp       = 1'b1;
      srsi_pkg::S_CLOSE_END: cmd_o.close_end = 1'b1;
      srsi_pkg::S_DONE:      cmd_o.load_out  = status_i.out_free;
      default:               cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srsi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/srsi_datapath.sv
`timescale 1ns / 1ps

module srsi_datapath #(
  parameter int unsigned MAX_REFS  = 1024,
  parameter int unsigned REF_WIDTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  srsi_pkg::dp_cmd_t                    cmd_i,
  output srsi_pkg::dp_status_t                 status_o,
  input  srsi_pkg::mode_e                      mode_i,
  input  logic [srsi_pkg::RefInW-1:0]          ref_value_i,
  input  logic [srsi_pkg::IndexInW-1:0]        read_index_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output srsi_pkg::status_e                    out_status_o,
  output logic [srsi_pkg::CountOutW-1:0]       out_count_o,
  output logic [srsi_pkg::RefInW-1:0]          out_value_o
);

  localparam int unsigned CntW = $clog2(MAX_REFS + 1);
  localparam int unsigned IdxW = $clog2(MAX_REFS);

  logic [REF_WIDTH-1:0] set_mem  [MAX_REFS];
  logic [REF_WIDTH-1:0] list_mem [MAX_REFS];
  logic [REF_WIDTH-1:0] set_rd_q, list_rd_q;

  logic                 set_we, set_re, list_we, list_re;
  logic [IdxW-1:0]      set_waddr, set_raddr, list_waddr, list_raddr;
  logic [REF_WIDTH-1:0] set_wdata, list_wdata;

  logic [CntW-1:0]      set_len_q, set_len_d, list_len_q, list_len_d;
  logic [CntW-1:0]      idx_q, idx_d, kept_q, kept_d;
  logic [CntW-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                 first_q, first_d;
  logic [REF_WIDTH-1:0] prev_q, prev_d;
  srsi_pkg::status_e    res_status_q, res_status_d;
  logic                 res_read_q, res_read_d;
  logic                 out_valid_q, out_valid_d;
  srsi_pkg::status_e    out_status_q;
  logic [srsi_pkg::CountOutW-1:0] out_count_q;
  logic [srsi_pkg::RefInW-1:0]    out_value_q;

  logic [REF_WIDTH-1:0] value_w;
  logic [CntW:0]        mid_sum;
  logic [CntW-1:0]      mid_w, idx_inc;
  logic                 push_full, push_order, read_beyond;

  assign value_w     = REF_WIDTH'(ref_value_i);
  assign mid_sum     = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w       = mid_sum[CntW:1];
  assign idx_inc     = idx_q + CntW'(1);
  assign push_full   = (list_len_q == CntW'(MAX_REFS));
  assign push_order  = (list_len_q != '0) && (value_w < prev_q);
  assign read_beyond = (32'(read_index_i) >= 32'(set_len_q)) || (32'(read_index_i) >= MAX_REFS);

  assign status_o.first      = first_q;
  assign status_o.set_empty  = (set_len_q == '0);
  assign status_o.list_empty = (list_len_q == '0);
  assign status_o.lo_lt_hi   = (lo_q < hi_q);
  assign status_o.match      = (list_rd_q == set_rd_q);
  assign status_o.walk_last  = (idx_inc == set_len_q);
  assign status_o.copy_last  = (idx_inc == list_len_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    set_len_d    = set_len_q;
    list_len_d   = list_len_q;
    idx_d        = idx_q;
    kept_d       = kept_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    first_d      = first_q;
    prev_d       = prev_q;
    res_status_d = res_status_q;
    res_read_d   = res_read_q;
    set_we       = 1'b0;
    set_re       = 1'b0;
    list_we      = 1'b0;
    list_re      = 1'b0;
    set_waddr    = idx_q[IdxW-1:0];
    set_raddr    = idx_q[IdxW-1:0];
    list_waddr   = list_len_q[IdxW-1:0];
    list_raddr   = idx_q[IdxW-1:0];
    set_wdata    = list_rd_q;
    list_wdata   = value_w;

    if (cmd_i.accept) begin
      res_status_d = srsi_pkg::ST_OK;
      res_read_d   = 1'b0;
      case (mode_i)
        srsi_pkg::MODE_NEW: begin
          set_len_d  = '0;
          list_len_d = '0;
          first_d    = 1'b1;
          prev_d     = '0;
        end
        srsi_pkg::MODE_PUSH: begin
          if (push_full) begin
            res_status_d = srsi_pkg::ST_FULL;
          end else if (push_order) begin
            res_status_d = srsi_pkg::ST_ORDER;
          end else begin
            list_we    = 1'b1;
            list_len_d = list_len_q + CntW'(1);
            prev_d     = value_w;
          end
        end
        srsi_pkg::MODE_CLOSE: begin
          idx_d  = '0;
          kept_d = '0;
        end
        srsi_pkg::MODE_READ: begin
          res_read_d = 1'b1;
          set_raddr  = IdxW'(read_index_i);
          if (read_beyond) begin
            res_status_d = srsi_pkg::ST_RANGE;
          end else begin
            set_re = 1'b1;
          end
        end
        default: res_status_d = srsi_pkg::ST_OK;
      endcase
    end

    if (cmd_i.copy_rd) begin
      list_re = 1'b1;
    end

    if (cmd_i.copy_wr) begin
      set_we = 1'b1;
      idx_d  = idx_inc;
    end

    if (cmd_i.set_rd) begin
      set_re = 1'b1;
      lo_d   = '0;
      hi_d   = list_len_q;
    end

    // one bisection step: read the middle list entry, or give up on a miss
    if (cmd_i.probe) begin
      if (lo_q < hi_q) begin
        list_re    = 1'b1;
        list_raddr = mid_w[IdxW-1:0];
        mid_d      = mid_w;
      end else begin
        idx_d = idx_inc;
      end
    end

    // kept entries compact toward the front, never past the walk position
    if (cmd_i.cmp) begin
      if (list_rd_q == set_rd_q) begin
        set_we    = 1'b1;
        set_waddr = kept_q[IdxW-1:0];
        set_wdata = set_rd_q;
        kept_d    = kept_q + CntW'(1);
        idx_d     = idx_inc;
      end else if (list_rd_q < set_rd_q) begin
        lo_d = mid_q + CntW'(1);
      end else begin
        hi_d = mid_q;
      end
    end

    if (cmd_i.close_end) begin
      set_len_d  = first_q ? list_len_q : kept_q;
      first_d    = 1'b0;
      list_len_d = '0;
      prev_d     = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_len_q    <= '0;
      list_len_q   <= '0;
      idx_q        <= '0;
      kept_q       <= '0;
      lo_q         <= '0;
      hi_q         <= '0;
      mid_q        <= '0;
      first_q      <= 1'b1;
      prev_q       <= '0;
      res_status_q <= srsi_pkg::ST_OK;
      res_read_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      set_len_q    <= set_len_d;
      list_len_q   <= list_len_d;
      idx_q        <= idx_d;
      kept_q       <= kept_d;
      lo_q         <= lo_d;
      hi_q         <= hi_d;
      mid_q        <= mid_d;
      first_q      <= first_d;
      prev_q       <= prev_d;
      res_status_q <= res_status_d;
      res_read_q   <= res_read_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_count_q  <= srsi_pkg::CountOutW'(set_len_q);
      if (res_read_q && (res_status_q == srsi_pkg::ST_OK)) begin
        out_value_q <= srsi_pkg::RefInW'(set_rd_q);
      end else begin
        out_value_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_we) begin
      set_mem[set_waddr] <= set_wdata;
    end
    if (set_re) begin
      set_rd_q <= set_mem[set_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (list_we) begin
      list_mem[list_waddr] <= list_wdata;
    end
    if (list_re) begin
      list_rd_q <= list_mem[list_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_count_o  = out_count_q;
  assign out_value_o  = out_value_q;

endmodule

>>> src/sorted_reference_set_intersection_top.sv
// new query, push and read go from accept straight to the done state and the output register
// closing the first list of a query copies its L list entries into the set (copy loop)
// closing a later list bisects the list for each of the S set entries, one probe of the
// list memory at a time; a new word is taken only once the last has reached the output register
// reset: control state, lengths and the first-list flag clear at once; no memory
// clearing pass, so the block takes words as soon as reset is released
`timescale 1ns / 1ps

module sorted_reference_set_intersection_top #(
  parameter int unsigned MAX_REFS  = 1024,
  parameter int unsigned REF_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] ref_value, [41:32] read_index, rest zero
  input  logic [srsi_pkg::InTdataW-1:0]      s_axis_tdata,
  // [1:0] mode
  input  logic [srsi_pkg::ModeW-1:0]         s_axis_tuser,
  // master side
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [10:0] set_count, [42:11] read_value, rest zero
  output logic [srsi_pkg::OutTdataW-1:0]     m_axis_tdata,
  // [1:0] status
  output logic [srsi_pkg::StatusW-1:0]       m_axis_tuser
);

  srsi_pkg::dp_cmd_t    cmd;
  srsi_pkg::dp_status_t dp_status;
  srsi_pkg::mode_e      mode;
  srsi_pkg::status_e    out_status;
  logic [srsi_pkg::CountOutW-1:0] out_count;
  logic [srsi_pkg::RefInW-1:0]    out_value;

  assign mode = srsi_pkg::mode_e'(s_axis_tuser);

  // sequencer: accepts only while idle, runs copy or bisection walks on close
  srsi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .mode_i     (mode),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  // set and list memories, lengths, search bounds and the output register
  srsi_datapath #(
    .MAX_REFS  (MAX_REFS),
    .REF_WIDTH (REF_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (dp_status),
    .mode_i       (mode),
    .ref_value_i  (s_axis_tdata[srsi_pkg::RefInW-1:0]),
    .read_index_i (s_axis_tdata[srsi_pkg::RefInW +: srsi_pkg::IndexInW]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (out_status),
    .out_count_o  (out_count),
    .out_value_o  (out_value)
  );

  // pack the result word, count in the low bits
  assign m_axis_tdata = {{srsi_pkg::OutPadW{1'b0}}, out_value, out_count};
  assign m_axis_tuser = out_status;

  `include "sorted_reference_set_intersection_top_assert.svh"

  // the output register is only loaded when it is empty or being drained
  `SRSI_ASSERT_SAME(a_load_into_free, clk_i, rst_ni, cmd.load_out, dp_status.out_free)
  // an accepted word always leaves the idle state
  `SRSI_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // the sequencer drives at most one datapath step per cycle
  `SRSI_ASSERT_SAME(a_single_step, clk_i, rst_ni, 1'b1, $onehot0(cmd))

endmodule

>>> tb/tb_sorted_reference_set_intersection_top.sv
`timescale 1ns / 1ps

module tb_sorted_reference_set_intersection_top;
  import srsi_pkg::*;

  localparam int unsigned MaxRefs    = 1024;
  localparam int unsigned TotalWords = 1200;

  // one response word as the block should return it
  typedef struct packed {
    status_e     status;
    logic [10:0] count;
    logic [31:0] value;
  } response_t;

  // running model of the intersection set and the open list
  class intersection_scoreboard;
    logic [31:0]  set_mem[MaxRefs];
    logic [31:0]  list_mem[MaxRefs];
    int unsigned  set_len;
    int unsigned  list_len;
    bit           first_list;
    logic [31:0]  last_pushed;
    response_t    pending_responses[$];
    int unsigned  errors;

    function new();
      set_len     = 0;
      list_len    = 0;
      first_list  = 1'b1;
      last_pushed = '0;
      errors      = 0;
    endfunction

    // bisection over the sorted open list
    function bit list_has(logic [31:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lo = 0;
      hi = list_len;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (list_mem[mid] == key) return 1'b1;
        if (list_mem[mid] < key) lo = mid + 1;
        else hi = mid;
      end
      return 1'b0;
    endfunction

    function void close_list();
      int unsigned kept;
      if (first_list) begin
        for (int unsigned i = 0; i < list_len; i++) set_mem[i] = list_mem[i];
        set_len    = list_len;
        first_list = 1'b0;
      end else begin
        kept = 0;
        for (int unsigned i = 0; i < set_len; i++) begin
          if (list_has(set_mem[i])) begin
            set_mem[kept] = set_mem[i];
            kept++;
          end
        end
        set_len = kept;
      end
      list_len    = 0;
      last_pushed = '0;
    endfunction

    function void note_word(mode_e mode, logic [31:0] ref_val, logic [9:0] idx);
      response_t rsp;
      rsp.status = ST_OK;
      rsp.value  = '0;
      case (mode)
        MODE_NEW: begin
          set_len     = 0;
          list_len    = 0;
          first_list  = 1'b1;
          last_pushed = '0;
        end
        MODE_PUSH: begin
          if (list_len >= MaxRefs) begin
            rsp.status = ST_FULL;
          end else if (list_len > 0 && ref_val < last_pushed) begin
            rsp.status = ST_ORDER;
          end else begin
            list_mem[list_len] = ref_val;
            list_len++;
            last_pushed = ref_val;
          end
        end
        MODE_CLOSE: close_list();
        default: begin
          if (idx >= set_len) rsp.status = ST_RANGE;
          else rsp.value = set_mem[idx];
        end
      endcase
      rsp.count = 11'(set_len);
      pending_responses.push_back(rsp);
    endfunction

    function void check_word(status_e status, logic [10:0] count, logic [31:0] value);
      response_t want;
      if (pending_responses.size() == 0) begin
        $error("response word with nothing pending");
        errors++;
        return;
      end
      want = pending_responses.pop_front();
      if (want.status !== status) begin
        $error("status: expected %0d, got %0d", want.status, status);
        errors++;
      end
      if (want.count !== count) begin
        $error("set_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
      if (want.value !== value) begin
        $error("read_value: expected %h, got %h", want.value, value);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_responses.size();
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  wire                  s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata  = '0;
  logic [ModeW-1:0]     s_axis_tuser  = MODE_NEW;
  wire                  m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  wire [OutTdataW-1:0]  m_axis_tdata;
  wire [StatusW-1:0]    m_axis_tuser;

  intersection_scoreboard sb = new();

  // no idling on either side while set
  bit          calm       = 1'b0;
  int unsigned words_sent = 0;

  sorted_reference_set_intersection_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  // valid drops only for a random gap before a word, else stays high across back-to-back words
  task automatic send_word(mode_e mode, logic [31:0] ref_val, logic [9:0] idx);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, idx, ref_val};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(mode, ref_val, idx);
    words_sent++;
    if ($urandom_range(0, 39) == 0) calm = !calm;
  endtask

  task automatic pause_until_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // response side
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_word(status_e'(m_axis_tuser), m_axis_tdata[10:0], m_axis_tdata[42:11]);
    end
  end

  initial begin
    logic [31:0] fill_vals[MaxRefs];
    logic [31:0] pool[24];
    logic [31:0] base;
    int unsigned pool_len;
    int unsigned n_lists;
    int unsigned n_reads;
    int unsigned reps;
    int unsigned drain;
    bit          keep_all;
    bit          drop_all;
    logic [9:0]  idx;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // read on an empty set, then an empty first list
    send_word(MODE_READ, 32'd0, 10'd0);
    send_word(MODE_CLOSE, 32'd0, 10'd0);
    // later list against an empty set
    send_word(MODE_PUSH, 32'd5, 10'd0);
    send_word(MODE_CLOSE, 32'd0, 10'd0);
    // first list with equal values and an out-of-order drop
    send_word(MODE_NEW, 32'hFFFF_FFFF, 10'd1023);
    send_word(MODE_PUSH, 32'd0, 10'd0);
    send_word(MODE_PUSH, 32'd0, 10'd0);
    send_word(MODE_PUSH, 32'hFFFF_FFFF, 10'd0);
    send_word(MODE_PUSH, 32'd7, 10'd0);
    send_word(MODE_PUSH, 32'hFFFF_FFFF, 10'd0);
    send_word(MODE_CLOSE, 32'd0, 10'd0);
    send_word(MODE_READ, 32'd0, 10'd0);
    send_word(MODE_READ, 32'd0, 10'd3);
    send_word(MODE_READ, 32'd0, 10'd4);
    send_word(MODE_READ, 32'd0, 10'd1023);
    // duplicates in the set survive a single match
    send_word(MODE_PUSH, 32'd0, 10'd0);
    send_word(MODE_PUSH, 32'hFFFF_FFFF, 10'd0);
    send_word(MODE_CLOSE, 32'd0, 10'd0);
    send_word(MODE_READ, 32'd0, 10'd1);
    // no match empties the set
    send_word(MODE_PUSH, 32'h1234_5678, 10'd0);
    send_word(MODE_CLOSE, 32'd0, 10'd0);
    // new query in the middle of a list
    send_word(MODE_PUSH, 32'h8000_0000, 10'd0);
    send_word(MODE_NEW, 32'd0, 10'd0);
    send_word(MODE_PUSH, 32'd1, 10'd0);
    send_word(MODE_CLOSE, 32'd0, 10'd0);
    send_word(MODE_READ, 32'd0, 10'd0);

    // fill the list store, then run a full-size intersection
    pause_until_idle();
    send_word(MODE_NEW, $urandom, 10'($urandom_range(0, 1023)));
    for (int k = 0; k < MaxRefs; k++) begin
      fill_vals[k] = (32'(k) << 22) | 32'($urandom_range(0, (1 << 22) - 1));
      send_word(MODE_PUSH, fill_vals[k], 10'($urandom_range(0, 1023)));
    end
    send_word(MODE_PUSH, 32'hFFFF_FFFF, 10'd0);
    send_word(MODE_PUSH, 32'd0, 10'd0);
    send_word(MODE_CLOSE, $urandom, 10'd0);
    send_word(MODE_READ, $urandom, 10'd1023);
    send_word(MODE_READ, $urandom, 10'd0);
    for (int k = 0; k < 64; k++) begin
      send_word(MODE_PUSH, fill_vals[k * 16], 10'($urandom_range(0, 1023)));
    end
    send_word(MODE_CLOSE, $urandom, 10'd0);
    send_word(MODE_READ, $urandom, 10'd63);
    send_word(MODE_READ, $urandom, 10'd64);
    pause_until_idle();

    // random queries built from a small sorted pool so lists overlap
    while (words_sent < TotalWords) begin
      send_word(MODE_NEW, $urandom, 10'($urandom_range(0, 1023)));
      pool_len = $urandom_range(1, 24);
      base = $urandom_range(0, 32'hF000_0000);
      for (int k = 0; k < pool_len; k++) begin
        pool[k] = base;
        if ($urandom_range(0, 3) != 0) base = base + $urandom_range(1, 1 << 20);
      end
      n_lists = $urandom_range(1, 4);
      for (int l = 0; l < n_lists; l++) begin
        keep_all = ($urandom_range(0, 3) == 0);
        drop_all = ($urandom_range(0, 9) == 0);
        for (int k = 0; k < pool_len; k++) begin
          if (!drop_all && (keep_all || $urandom_range(0, 2) != 0)) begin
            reps = ($urandom_range(0, 7) == 0) ? 2 : 1;
            repeat (reps) send_word(MODE_PUSH, pool[k], 10'($urandom_range(0, 1023)));
          end
          // stray push, usually out of order afterwards
          if ($urandom_range(0, 24) == 0)
            send_word(MODE_PUSH, $urandom, 10'($urandom_range(0, 1023)));
        end
        if ($urandom_range(0, 29) == 0)
          send_word(mode_e'($urandom_range(0, 3)), $urandom, 10'($urandom_range(0, 1023)));
        send_word(MODE_CLOSE, $urandom, 10'($urandom_range(0, 1023)));
        n_reads = $urandom_range(0, 3);
        repeat (n_reads) begin
          if ($urandom_range(0, 4) == 0) idx = 10'($urandom_range(0, 1023));
          else idx = 10'($urandom_range(0, sb.set_len + 1));
          send_word(MODE_READ, $urandom, idx);
        end
      end
      if ($urandom_range(0, 29) == 0) pause_until_idle();
    end
    s_axis_tvalid <= 1'b0;

    drain = 0;
    while (sb.pending() != 0 && drain < 100000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d response words never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
